// ----- hdl/nat_pkg.sv -----
// Shared types, constants and a helper function for the source NAT prefix-match block.
package nat_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SLOT_W        = 6;
  localparam int LEN_W         = 6;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CMP_W         = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [15:0]      MIN_FRAME_BYTES = 16'd34;
  localparam logic [LEN_W-1:0] MAX_PREFIX_LEN  = 6'd32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_PACKET = 1'b1;

  typedef enum logic [1:0] {
    ST_MISS    = 2'd0,
    ST_REWRITE = 2'd1,
    ST_SHORT   = 2'd2,
    ST_WRITE   = 2'd3
  } status_t;

  // One request as it travels down the cell chain, with the best match found so far.
  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       prefix;
    logic [LEN_W-1:0]  plen;
    logic [31:0]       new_addr;
    logic              ent_valid;
    logic              short_frame;
    logic [31:0]       w0;
    logic [31:0]       w1;
    logic [31:0]       w2;
    logic [31:0]       src;
    logic [31:0]       w4;
    logic              hit;
    logic [LEN_W-1:0]  best_len;
    logic [31:0]       best_addr;
  } item_t;

  // Leading-ones mask for a prefix length of 0 to 32.
  function automatic logic [31:0] len_mask(input logic [LEN_W-1:0] len);
    len_mask = ~(32'hffff_ffff >> len);
  endfunction

endpackage

// ----- hdl/nat_cell.sv -----
// One cell of the prefix chain: holds a table entry and updates the passing request.
module nat_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [nat_pkg::IDX_W-1:0] cell_idx,
  input  logic                     in_vld,
  input  nat_pkg::item_t           in_item,
  output logic                     out_vld,
  output nat_pkg::item_t           out_item
);

  localparam int CW = nat_pkg::CMP_W;

  logic                          vld_r;
  nat_pkg::item_t                item_r;
  nat_pkg::item_t                item_nxt;
  logic                          ent_vld_r;
  logic                          ent_vld_nxt;
  logic [31:0]                   ent_prefix_r;
  logic [31:0]                   ent_prefix_nxt;
  logic [nat_pkg::LEN_W-1:0]     ent_len_r;
  logic [nat_pkg::LEN_W-1:0]     ent_len_nxt;
  logic [31:0]                   ent_addr_r;
  logic [31:0]                   ent_addr_nxt;
  logic                          wr;
  logic                          match;

  assign wr = adv && in_vld && (in_item.mode == nat_pkg::MODE_WRITE) &&
              (CW'(in_item.slot) == CW'(cell_idx));

  assign match = ent_vld_r && (in_item.mode == nat_pkg::MODE_PACKET) &&
                 !in_item.short_frame &&
                 (((in_item.src ^ ent_prefix_r) & nat_pkg::len_mask(ent_len_r)) == 32'd0);

  always_comb begin
    item_nxt       = in_item;
    ent_vld_nxt    = ent_vld_r;
    ent_prefix_nxt = ent_prefix_r;
    ent_len_nxt    = ent_len_r;
    ent_addr_nxt   = ent_addr_r;
    // A strictly longer prefix is needed to displace an earlier slot.
    if (match && (!in_item.hit || (ent_len_r > in_item.best_len))) begin
      item_nxt.hit       = 1'b1;
      item_nxt.best_len  = ent_len_r;
      item_nxt.best_addr = ent_addr_r;
    end
    if (wr) begin
      ent_vld_nxt    = in_item.ent_valid;
      ent_prefix_nxt = in_item.prefix;
      ent_len_nxt    = in_item.plen;
      ent_addr_nxt   = in_item.new_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      ent_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= in_vld;
      ent_vld_r <= ent_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r       <= item_nxt;
      ent_prefix_r <= ent_prefix_nxt;
      ent_len_r    <= ent_len_nxt;
      ent_addr_r   <= ent_addr_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

// ----- hdl/nat_csum.sv -----
// Result stage: header checksum recomputation and the output register.
module nat_csum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  nat_pkg::item_t  in_item,
  output logic            out_vld,
  output nat_pkg::status_t out_status,
  output logic [31:0]     out_src,
  output logic [15:0]     out_csum
);

  logic             vld_r;
  nat_pkg::status_t status_r;
  nat_pkg::status_t status_nxt;
  logic [31:0]      src_r;
  logic [31:0]      src_nxt;
  logic [15:0]      csum_r;
  logic [15:0]      csum_nxt;
  logic [19:0]      sum;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  // Nine halfwords: the checksum field itself counts as zero.
  assign sum = 20'(in_item.w0[31:16]) + 20'(in_item.w0[15:0]) +
               20'(in_item.w1[31:16]) + 20'(in_item.w1[15:0]) +
               20'(in_item.w2[31:16]) +
               20'(in_item.best_addr[31:16]) + 20'(in_item.best_addr[15:0]) +
               20'(in_item.w4[31:16]) + 20'(in_item.w4[15:0]);
  assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    status_nxt = nat_pkg::ST_MISS;
    src_nxt    = in_item.src;
    csum_nxt   = in_item.w2[15:0];
    priority if (in_item.mode == nat_pkg::MODE_WRITE) begin
      status_nxt = nat_pkg::ST_WRITE;
      src_nxt    = 32'd0;
      csum_nxt   = 16'd0;
    end else if (in_item.short_frame) begin
      status_nxt = nat_pkg::ST_SHORT;
    end else if (in_item.hit) begin
      status_nxt = nat_pkg::ST_REWRITE;
      src_nxt    = in_item.best_addr;
      csum_nxt   = ~fold2;
    end else begin
      status_nxt = nat_pkg::ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      src_r    <= src_nxt;
      csum_r   <= csum_nxt;
    end
  end

  assign out_vld    = vld_r;
  assign out_status = status_r;
  assign out_src    = src_r;
  assign out_csum   = csum_r;

endmodule

// ----- hdl/ipv4_source_nat_lpm_rewrite.sv -----
// Top level of the IPv4 source NAT block with longest-prefix-match lookup.
// Pipeline: the first cell registers the request at the accepting edge, each of the
// TABLE_ENTRIES cells registers it in turn, and the result register follows the last cell.
// Throughput: one request per cycle; the whole cell chain advances together and stalls
// only while a result waits in the output register.
// Reset: synchronous active-low rst_n clears every stage valid and every entry valid mark;
// entry contents are left as they are and no clearing pass is needed.
module ipv4_source_nat_lpm_rewrite (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_slot, entry_prefix, entry_prefix_len, entry_new_addr, entry_valid,
  // frame_length, hdr_word0, hdr_word1, hdr_word2, hdr_word3, hdr_word4, zero pad
  input  logic [255:0] in_tdata,
  // mode
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_source_addr, out_checksum
  output logic [47:0]  out_tdata,
  // status
  output logic [1:0]   out_tuser
);

  localparam int N  = nat_pkg::TABLE_ENTRIES;
  localparam int IW = nat_pkg::IDX_W;

  logic             adv;
  logic             vld_chain [0:N];
  nat_pkg::item_t   item_chain [0:N];
  nat_pkg::item_t   in_item;
  logic [5:0]       raw_len;
  nat_pkg::status_t out_status;
  logic [31:0]      out_src;
  logic [15:0]      out_csum;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign raw_len = in_tdata[43:38];

  always_comb begin
    in_item             = '0;
    in_item.mode        = in_tuser[0];
    in_item.slot        = in_tdata[5:0];
    in_item.prefix      = in_tdata[37:6];
    in_item.plen        = (raw_len > nat_pkg::MAX_PREFIX_LEN) ?
                          nat_pkg::MAX_PREFIX_LEN : raw_len;
    in_item.new_addr    = in_tdata[75:44];
    in_item.ent_valid   = in_tdata[76];
    in_item.short_frame = in_tdata[92:77] < nat_pkg::MIN_FRAME_BYTES;
    in_item.w0          = in_tdata[124:93];
    in_item.w1          = in_tdata[156:125];
    in_item.w2          = in_tdata[188:157];
    in_item.src         = in_tdata[220:189];
    in_item.w4          = in_tdata[252:221];
    in_item.hit         = 1'b0;
  end

  assign vld_chain[0]  = in_tvalid;
  assign item_chain[0] = in_item;

  for (genvar g = 0; g < N; g++) begin : g_cell
    nat_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (IW'(g)),
      .in_vld   (vld_chain[g]),
      .in_item  (item_chain[g]),
      .out_vld  (vld_chain[g+1]),
      .out_item (item_chain[g+1])
    );
  end

  nat_csum u_csum (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (vld_chain[N]),
    .in_item    (item_chain[N]),
    .out_vld    (out_tvalid),
    .out_status (out_status),
    .out_src    (out_src),
    .out_csum   (out_csum)
  );

  assign out_tdata = {out_csum, out_src};
  assign out_tuser = out_status;

  // A table write always reports zero address and checksum.
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == nat_pkg::ST_WRITE)) |-> (out_tdata == 48'd0))
    else $error("table write result carries non-zero data");

  // A stalled result must hold the whole chain still.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> (!in_tready && !adv))
    else $error("chain advanced while the result was stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 source NAT block with longest-prefix-match lookup.
module tb;
  import nat_pkg::*;

  localparam int MAX_GAP         = 16;
  localparam int RANDOM_REQUESTS = 1500;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 2 * TABLE_ENTRIES + 20;

  // Input request laid out as on in_tdata; the first field sits in the lowest bits.
  typedef struct packed {
    logic [2:0]        pad;
    logic [31:0]       w4;
    logic [31:0]       w3;
    logic [31:0]       w2;
    logic [31:0]       w1;
    logic [31:0]       w0;
    logic [15:0]       frame_len;
    logic              ent_valid;
    logic [31:0]       new_addr;
    logic [LEN_W-1:0]  plen;
    logic [31:0]       prefix;
    logic [SLOT_W-1:0] slot;
  } nat_req_t;

  typedef struct {
    status_t     status;
    logic [31:0] src;
    logic [15:0] csum;
  } nat_result_t;

  class nat_result_board;
    logic [31:0]      prefix_tab [TABLE_ENTRIES];
    logic [LEN_W-1:0] plen_tab   [TABLE_ENTRIES];
    logic [31:0]      addr_tab   [TABLE_ENTRIES];
    bit               valid_tab  [TABLE_ENTRIES];
    nat_result_t      due_q[$];
    int errors;
    int n_writes;
    int n_rewrites;
    int n_misses;
    int n_short;

    function new();
      foreach (valid_tab[i]) valid_tab[i] = 1'b0;
      errors     = 0;
      n_writes   = 0;
      n_rewrites = 0;
      n_misses   = 0;
      n_short    = 0;
    endfunction

    // Ones-complement header sum with the checksum field taken as zero.
    function logic [15:0] hdr_checksum(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                       logic [31:0] src, logic [31:0] w4);
      logic [31:0] s;
      s = 32'(w0[31:16]) + 32'(w0[15:0]) + 32'(w1[31:16]) + 32'(w1[15:0])
        + 32'(w2[31:16]) + 32'(src[31:16]) + 32'(src[15:0])
        + 32'(w4[31:16]) + 32'(w4[15:0]);
      for (int k = 0; k < 4; k++) begin
        if (s[31:16] != 16'd0) s = 32'(s[15:0]) + 32'(s[31:16]);
      end
      return ~s[15:0];
    endfunction

    function nat_result_t translate_header(logic mode, nat_req_t r);
      nat_result_t      res;
      logic             hit;
      logic [LEN_W-1:0] best_len;
      logic [LEN_W-1:0] len;
      logic [31:0]      best_addr;
      logic [31:0]      mask;
      hit       = 1'b0;
      best_len  = '0;
      best_addr = '0;
      if (mode == MODE_WRITE) begin
        if (int'(r.slot) < TABLE_ENTRIES) begin
          prefix_tab[r.slot] = r.prefix;
          plen_tab[r.slot]   = (r.plen > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : r.plen;
          addr_tab[r.slot]   = r.new_addr;
          valid_tab[r.slot]  = r.ent_valid;
        end
        res = '{ST_WRITE, 32'd0, 16'd0};
      end else if (r.frame_len < MIN_FRAME_BYTES) begin
        res = '{ST_SHORT, r.w3, r.w2[15:0]};
      end else begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (valid_tab[i]) begin
            len  = plen_tab[i];
            mask = ~(32'hffff_ffff >> len);
            // Strictly longer only, so the lowest slot keeps an equal-length tie.
            if ((((r.w3 ^ prefix_tab[i]) & mask) == 32'd0) && (!hit || len > best_len)) begin
              hit       = 1'b1;
              best_len  = len;
              best_addr = addr_tab[i];
            end
          end
        end
        if (hit) res = '{ST_REWRITE, best_addr, hdr_checksum(r.w0, r.w1, r.w2, best_addr, r.w4)};
        else res = '{ST_MISS, r.w3, r.w2[15:0]};
      end
      return res;
    endfunction

    function void note_request(logic mode, nat_req_t r);
      nat_result_t res;
      res = translate_header(mode, r);
      case (res.status)
        ST_WRITE:   n_writes++;
        ST_SHORT:   n_short++;
        ST_REWRITE: n_rewrites++;
        default:    n_misses++;
      endcase
      due_q.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [47:0] d);
      nat_result_t want;
      if (due_q.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (status != want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (d[31:0] != want.src) begin
        $error("out_source_addr: expected %h, actual %h", want.src, d[31:0]);
        errors++;
      end
      if (d[47:32] != want.csum) begin
        $error("out_checksum: expected %h, actual %h", want.csum, d[47:32]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata   = '0;
  logic [0:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;

  nat_result_board board = new();
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int idle_cycles = 0;

  ipv4_source_nat_lpm_rewrite u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic nat_req_t random_req();
    nat_req_t r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom()};
    r.pad = '0;
    return r;
  endfunction

  // Starts and ends on a falling edge; valid stays high across back-to-back requests.
  task automatic send_request(logic mode, nat_req_t r);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(mode, r);
    @(negedge clk);
  endtask

  task automatic write_entry(logic [SLOT_W-1:0] slot, logic [31:0] prefix,
                             logic [LEN_W-1:0] plen, logic [31:0] new_addr, logic valid);
    nat_req_t r;
    r           = random_req();
    r.slot      = slot;
    r.prefix    = prefix;
    r.plen      = plen;
    r.new_addr  = new_addr;
    r.ent_valid = valid;
    send_request(MODE_WRITE, r);
  endtask

  task automatic send_packet(logic [15:0] frame_len, logic [31:0] src);
    nat_req_t r;
    r           = random_req();
    r.frame_len = frame_len;
    r.w3        = src;
    send_request(MODE_PACKET, r);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, with runs of none at all.
  initial begin
    int gap;
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_result(out_tuser, out_tdata);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] bases [8];
    logic [31:0] base;
    nat_req_t    r;
    int          pick;

    foreach (bases[i]) bases[i] = $urandom();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table: everything misses.
    send_packet(16'hffff, 32'hffff_ffff);
    send_packet(16'd34, 32'h0000_0000);
    write_entry(6'd0, 32'h0a00_0000, 6'd8, 32'hc633_6401, 1'b1);
    write_entry(6'd1, 32'h0a01_0000, 6'd16, 32'hc633_6402, 1'b1);
    write_entry(6'd63, 32'h0a01_0203, 6'd32, 32'hc633_6403, 1'b1);
    // A length above 32 is held at 32.
    write_entry(6'd2, 32'hc0a8_0101, 6'd63, 32'hcb00_7101, 1'b1);
    // Same length, different bits past the prefix: the lower slot must win.
    write_entry(6'd10, 32'hac10_0000, 6'd24, 32'h6440_0001, 1'b1);
    write_entry(6'd11, 32'hac10_00ff, 6'd24, 32'h6440_0002, 1'b1);
    send_packet(16'd1500, 32'h0a05_0505);
    send_packet(16'd1500, 32'h0a01_ffff);
    send_packet(16'd1500, 32'h0a01_0203);
    send_packet(16'd1500, 32'hc0a8_0101);
    send_packet(16'd1500, 32'hac10_0042);
    send_packet(16'd1500, 32'h0b00_0000);
    // Frame length just below, at and far under the minimum.
    send_packet(16'd0, 32'h0a05_0505);
    send_packet(16'd33, 32'h0a05_0505);
    send_packet(16'd34, 32'h0a05_0505);
    // A zero-length entry matches any source.
    write_entry(6'd5, 32'hffff_ffff, 6'd0, 32'h0808_0808, 1'b1);
    send_packet(16'd64, 32'h0b00_0000);
    send_packet(16'd64, 32'hffff_ffff);
    write_entry(6'd0, 32'h0a00_0000, 6'd8, 32'h0000_0000, 1'b0);
    send_packet(16'd64, 32'h0a05_0505);
    write_entry(6'd5, 32'h0000_0000, 6'd0, 32'hffff_ffff, 1'b0);
    send_packet(16'd64, 32'h0b00_0000);

    drain_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 99) == 0) tx_burst = !tx_burst;
      if (n == RANDOM_REQUESTS / 2) drain_results();
      r    = random_req();
      base = bases[$urandom_range(0, 7)];
      if ($urandom_range(0, 99) < 15) begin
        r.prefix    = base ^ ($urandom() >> $urandom_range(0, 31));
        pick        = $urandom_range(0, 19);
        r.plen      = (pick == 0) ? 6'd0 :
                      (pick == 1) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(1, 32));
        r.ent_valid = ($urandom_range(0, 6) != 0);
        send_request(MODE_WRITE, r);
      end else begin
        if ($urandom_range(0, 11) == 0) r.frame_len = 16'($urandom_range(0, 33));
        else r.frame_len = 16'($urandom_range(34, 65535));
        // Most sources sit near an installed prefix so that lookups go deep.
        if ($urandom_range(0, 3) != 0) r.w3 = base ^ ($urandom() >> $urandom_range(0, 31));
        send_request(MODE_PACKET, r);
      end
    end

    in_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d table writes, %0d rewrites, %0d misses and %0d short frames,",
             board.n_writes, board.n_rewrites, board.n_misses, board.n_short);
    $display("with random stalls on both sides and one full drain mid-run.");
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
